>>> src/i2cm_pkg.sv
// Shared types, constants and codes of the I2C master bit engine.
package i2cm_pkg;

    localparam int DELAY_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int BYTE_BITS       = 8;
    localparam int HALF_PERIOD_W   = 16;
    localparam int POLL_LIMIT_W    = 8;
    localparam int CFG_DATA_W      = 16;
    localparam int CFG_ADDR_W      = 1;

    localparam logic [HALF_PERIOD_W-1:0] HALF_PERIOD_RST = 16'd4;
    localparam logic [POLL_LIMIT_W-1:0]  POLL_LIMIT_RST  = 8'd250;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_HALF_PERIOD    = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ACK_POLL_LIMIT = 1'b1;

    typedef enum logic [2:0] {
        FN_NONE     = 3'd0,
        FN_START    = 3'd1,
        FN_STOP     = 3'd2,
        FN_SEND     = 3'd3,
        FN_WAIT_ACK = 3'd4,
        FN_RECV     = 3'd5,
        FN_ACK      = 3'd6,
        FN_NACK     = 3'd7
    } t_func;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'd0,
        PH_ST_B    = 5'd1,
        PH_ST_C    = 5'd2,
        PH_SP_A    = 5'd3,
        PH_SP_B    = 5'd4,
        PH_SP_C    = 5'd5,
        PH_SP_D    = 5'd6,
        PH_WA_A    = 5'd7,
        PH_WA_B    = 5'd8,
        PH_WA_POLL = 5'd9,
        PH_TX_A    = 5'd10,
        PH_TX_B    = 5'd11,
        PH_TX_C    = 5'd12,
        PH_RX_A    = 5'd13,
        PH_RX_B    = 5'd14,
        PH_RX_C    = 5'd15,
        PH_AK_A    = 5'd16,
        PH_AK_B    = 5'd17,
        PH_AK_C    = 5'd18,
        PH_ST_A    = 5'd19
    } t_phase;

    // One tick after classification in the front part.
    typedef struct packed {
        t_func                func;
        logic                 has_cmd;
        logic [BYTE_BITS-1:0] tx_byte;
        logic                 ack_after_read;
        logic                 sda_sample;
    } t_tick;

    typedef struct packed {
        logic                 scl_level;
        logic                 sda_level;
        logic                 sda_drive;
        logic                 busy_res;
        logic                 done_res;
        logic [BYTE_BITS-1:0] rx_byte;
        logic                 ack_missing;
    } t_result;

endpackage

>>> src/i2cm_fifo.sv
// Small first-in first-out queue built from flip-flops.
module i2cm_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> src/i2cm_front.sv
// Front part: accepts ticks, classifies the command and hands them to the queue.
module i2cm_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [2:0]                     i_func,
    input  logic [i2cm_pkg::BYTE_BITS-1:0] i_tx_byte,
    input  logic                           i_ack_after_read,
    input  logic                           i_sda_sample,
    input  logic                           i_q_full,
    output logic                           o_q_push,
    output i2cm_pkg::t_tick                o_tick
);
    import i2cm_pkg::*;

    logic  r_valid, n_valid;
    t_tick r_tick;
    t_tick cls_tick;
    logic  accept;

    assign full     = r_valid && i_q_full;
    assign accept   = push && !full;
    assign o_q_push = r_valid && !i_q_full;
    assign o_tick   = r_tick;

    always_comb begin
        cls_tick.func           = t_func'(i_func);
        cls_tick.has_cmd        = (t_func'(i_func) != FN_NONE);
        cls_tick.tx_byte        = i_tx_byte;
        cls_tick.ack_after_read = i_ack_after_read;
        cls_tick.sda_sample     = i_sda_sample;
    end

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_q_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tick <= cls_tick;
        end
    end

endmodule

>>> src/i2cm_back.sv
// Back part: the pin sequencer that advances one tick per step and emits results.
module i2cm_back #(
    parameter int DELAY_WIDTH = i2cm_pkg::DELAY_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [i2cm_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [i2cm_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                            i_tick_valid,
    input  i2cm_pkg::t_tick                 i_tick,
    output logic                            o_tick_pop,
    input  logic                            i_res_full,
    output logic                            o_res_push,
    output i2cm_pkg::t_result               o_res
);
    import i2cm_pkg::*;

    localparam int CMPW = (DELAY_WIDTH > HALF_PERIOD_W) ? DELAY_WIDTH : HALF_PERIOD_W;

    logic [HALF_PERIOD_W-1:0] r_half_period;
    logic [POLL_LIMIT_W-1:0]  r_poll_limit;

    t_phase                 r_phase,     n_phase;
    logic [BYTE_BITS-1:0]   r_shift,     n_shift;
    logic [3:0]             r_bit_cnt,   n_bit_cnt;
    logic [DELAY_WIDTH-1:0] r_delay,     n_delay;
    logic [7:0]             r_poll,      n_poll;
    logic                   r_scl,       n_scl;
    logic                   r_sda,       n_sda;
    logic                   r_sda_drive, n_sda_drive;
    logic                   r_ack_choice, n_ack_choice;
    logic                   r_ack_flag,  n_ack_flag;
    logic [BYTE_BITS-1:0]   r_rx_data,   n_rx_data;

    logic                   step;
    logic                   done;
    logic                   go, chain_go;
    t_phase                 seg, chain;
    logic [CMPW-1:0]        hp_ext, max_ext, load_ext;
    logic [DELAY_WIDTH-1:0] delay_load;

    assign step       = i_tick_valid && !i_res_full;
    assign o_tick_pop = step;
    assign o_res_push = step;

    // A zero half period counts as one; a value beyond the counter saturates.
    assign hp_ext  = CMPW'(r_half_period);
    assign max_ext = CMPW'({DELAY_WIDTH{1'b1}});
    always_comb begin
        if (hp_ext == '0) begin
            load_ext = CMPW'(1);
        end else if (hp_ext > max_ext) begin
            load_ext = max_ext;
        end else begin
            load_ext = hp_ext;
        end
    end
    assign delay_load = load_ext[DELAY_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HALF_PERIOD_RST;
            r_poll_limit  <= POLL_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_HALF_PERIOD:    r_half_period <= i_cfg_wdata;
                CFG_ACK_POLL_LIMIT: r_poll_limit  <= i_cfg_wdata[POLL_LIMIT_W-1:0];
                default:            r_half_period <= r_half_period;
            endcase
        end
    end

    // Next state: the first segment of a tick may chain straight into a second one.
    always_comb begin
        n_phase      = r_phase;
        n_shift      = r_shift;
        n_bit_cnt    = r_bit_cnt;
        n_delay      = r_delay;
        n_poll       = r_poll;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_sda_drive  = r_sda_drive;
        n_ack_choice = r_ack_choice;
        n_ack_flag   = r_ack_flag;
        n_rx_data    = r_rx_data;
        done         = 1'b0;
        go           = 1'b0;
        seg          = PH_IDLE;
        chain_go     = 1'b0;
        chain        = PH_IDLE;

        if (r_phase == PH_IDLE) begin
            if (i_tick.has_cmd) begin
                n_bit_cnt = '0;
                n_poll    = '0;
                go        = 1'b1;
                unique case (i_tick.func)
                    FN_START:    seg = PH_ST_A;
                    FN_STOP:     seg = PH_SP_A;
                    FN_SEND: begin
                        n_shift = i_tick.tx_byte;
                        seg     = PH_TX_A;
                    end
                    FN_WAIT_ACK: seg = PH_WA_A;
                    FN_RECV: begin
                        n_shift      = '0;
                        n_ack_choice = !i_tick.ack_after_read;
                        seg          = PH_RX_A;
                    end
                    FN_ACK: begin
                        n_ack_choice = 1'b0;
                        seg          = PH_AK_A;
                    end
                    FN_NACK: begin
                        n_ack_choice = 1'b1;
                        seg          = PH_AK_A;
                    end
                    default:     go = 1'b0;
                endcase
            end
        end else if (r_phase == PH_WA_POLL) begin
            go  = 1'b1;
            seg = PH_WA_POLL;
        end else begin
            n_delay = r_delay - DELAY_WIDTH'(r_delay != '0);
            go      = (n_delay == '0);
            seg     = r_phase;
        end

        if (go) begin
            unique case (seg)
                PH_ST_A: begin
                    n_sda_drive = 1'b1;
                    n_scl       = 1'b1;
                    n_sda       = 1'b1;
                    n_delay     = delay_load;
                    n_phase     = PH_ST_B;
                end
                PH_ST_B: begin
                    n_sda   = 1'b0;
                    n_delay = delay_load;
                    n_phase = PH_ST_C;
                end
                PH_ST_C: begin
                    n_scl   = 1'b0;
                    n_phase = PH_IDLE;
                    done    = 1'b1;
                end
                PH_SP_A: begin
                    chain_go = 1'b1;
                    chain    = PH_SP_A;
                end
                PH_SP_B: begin
                    n_scl   = 1'b1;
                    n_delay = delay_load;
                    n_phase = PH_SP_C;
                end
                PH_SP_C: begin
                    n_sda   = 1'b1;
                    n_delay = delay_load;
                    n_phase = PH_SP_D;
                end
                PH_SP_D: begin
                    n_phase = PH_IDLE;
                    done    = 1'b1;
                end
                PH_WA_A: begin
                    n_sda_drive = 1'b0;
                    n_sda       = 1'b1;
                    n_delay     = delay_load;
                    n_phase     = PH_WA_B;
                end
                PH_WA_B: begin
                    n_scl   = 1'b1;
                    n_delay = delay_load;
                    n_phase = PH_WA_POLL;
                end
                PH_WA_POLL: begin
                    if (!i_tick.sda_sample) begin
                        n_scl      = 1'b0;
                        n_ack_flag = 1'b0;
                        n_phase    = PH_IDLE;
                        done       = 1'b1;
                    end else if (r_poll >= r_poll_limit) begin
                        // Timeout: flag the missing acknowledge and release the bus.
                        n_ack_flag = 1'b1;
                        chain_go   = 1'b1;
                        chain      = PH_SP_A;
                    end else begin
                        n_poll = r_poll + 8'd1;
                    end
                end
                PH_TX_A: begin
                    chain_go = 1'b1;
                    chain    = PH_TX_A;
                end
                PH_TX_B: begin
                    n_scl   = 1'b0;
                    n_delay = delay_load;
                    n_phase = PH_TX_C;
                end
                PH_TX_C: begin
                    n_shift   = {n_shift[BYTE_BITS-2:0], 1'b0};
                    n_bit_cnt = n_bit_cnt + 4'd1;
                    if (n_bit_cnt < 4'(BYTE_BITS)) begin
                        chain_go = 1'b1;
                        chain    = PH_TX_A;
                    end else begin
                        n_phase = PH_IDLE;
                        done    = 1'b1;
                    end
                end
                PH_RX_A: begin
                    chain_go = 1'b1;
                    chain    = PH_RX_A;
                end
                PH_RX_B: begin
                    n_scl     = 1'b1;
                    n_shift   = {n_shift[BYTE_BITS-2:0], i_tick.sda_sample};
                    n_bit_cnt = n_bit_cnt + 4'd1;
                    n_delay   = delay_load;
                    n_phase   = PH_RX_C;
                end
                PH_RX_C: begin
                    chain_go = 1'b1;
                    if (n_bit_cnt < 4'(BYTE_BITS)) begin
                        chain = PH_RX_A;
                    end else begin
                        n_rx_data = n_shift;
                        chain     = PH_AK_A;
                    end
                end
                PH_AK_A: begin
                    chain_go = 1'b1;
                    chain    = PH_AK_A;
                end
                PH_AK_B: begin
                    n_scl   = 1'b1;
                    n_delay = delay_load;
                    n_phase = PH_AK_C;
                end
                PH_AK_C: begin
                    n_scl   = 1'b0;
                    n_phase = PH_IDLE;
                    done    = 1'b1;
                end
                default: n_phase = PH_IDLE;
            endcase
        end

        // Segments that open a bit or a stop, reached directly or by chaining.
        if (chain_go) begin
            unique case (chain)
                PH_SP_A: begin
                    n_sda_drive = 1'b1;
                    n_scl       = 1'b0;
                    n_sda       = 1'b0;
                    n_delay     = delay_load;
                    n_phase     = PH_SP_B;
                end
                PH_TX_A: begin
                    n_sda_drive = 1'b1;
                    n_sda       = n_shift[BYTE_BITS-1];
                    n_scl       = 1'b1;
                    n_delay     = delay_load;
                    n_phase     = PH_TX_B;
                end
                PH_RX_A: begin
                    n_sda_drive = 1'b0;
                    n_scl       = 1'b0;
                    n_delay     = delay_load;
                    n_phase     = PH_RX_B;
                end
                PH_AK_A: begin
                    n_scl       = 1'b0;
                    n_sda_drive = 1'b1;
                    n_sda       = n_ack_choice;
                    n_delay     = delay_load;
                    n_phase     = PH_AK_B;
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    // Outputs: the levels after this tick.
    always_comb begin
        o_res.scl_level   = n_scl;
        o_res.sda_level   = n_sda;
        o_res.sda_drive   = n_sda_drive;
        o_res.busy_res    = (n_phase != PH_IDLE);
        o_res.done_res    = done;
        o_res.rx_byte     = n_rx_data;
        o_res.ack_missing = n_ack_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_shift      <= '0;
            r_bit_cnt    <= '0;
            r_delay      <= '0;
            r_poll       <= '0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_sda_drive  <= 1'b1;
            r_ack_choice <= 1'b0;
            r_ack_flag   <= 1'b0;
            r_rx_data    <= '0;
        end else if (step) begin
            r_phase      <= n_phase;
            r_shift      <= n_shift;
            r_bit_cnt    <= n_bit_cnt;
            r_delay      <= n_delay;
            r_poll       <= n_poll;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
            r_sda_drive  <= n_sda_drive;
            r_ack_choice <= n_ack_choice;
            r_ack_flag   <= n_ack_flag;
            r_rx_data    <= n_rx_data;
        end
    end

endmodule

>>> src/i2c_master_bit_engine.sv
// Top level of the I2C master bit engine: front part, tick queue, sequencer, result queue.
//
// Each item is one timing tick and yields exactly one result item with the SCL/SDA levels,
// busy, done, the received byte and the ack-missing flag. One item is accepted every clock
// cycle and one result leaves every cycle, both only while the reader keeps popping; the sequencer
// advances its whole state for one tick in one step. A result reaches the result ports once
// its item has passed the front register and the tick queue and the sequencer step has
// written it into the result queue. Configuration writes take effect on the next cycle and
// belong to times when the block is idle.
module i2c_master_bit_engine #(
    parameter int DELAY_WIDTH = i2cm_pkg::DELAY_WIDTH_DEF,
    parameter int QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [i2cm_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [i2cm_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                            push,
    output logic                            full,
    input  logic [2:0]                      i_func,
    input  logic [i2cm_pkg::BYTE_BITS-1:0]  i_tx_byte,
    input  logic                            i_ack_after_read,
    input  logic                            i_sda_sample,
    output logic                            empty,
    input  logic                            pop,
    output logic                            o_scl_level,
    output logic                            o_sda_level,
    output logic                            o_sda_drive,
    output logic                            o_busy_res,
    output logic                            o_done_res,
    output logic [i2cm_pkg::BYTE_BITS-1:0]  o_rx_byte,
    output logic                            o_ack_missing
);
    import i2cm_pkg::*;

    localparam int TICK_W = $bits(t_tick);
    localparam int RES_W  = $bits(t_result);

    t_tick   front_tick;
    logic    front_push;
    logic    tq_full, tq_empty;
    t_tick   tq_tick;
    logic    tq_pop;
    logic    rq_full;
    logic    rq_push;
    t_result back_res;
    t_result rq_res;

    i2cm_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_func           (i_func),
        .i_tx_byte        (i_tx_byte),
        .i_ack_after_read (i_ack_after_read),
        .i_sda_sample     (i_sda_sample),
        .i_q_full         (tq_full),
        .o_q_push         (front_push),
        .o_tick           (front_tick)
    );

    i2cm_fifo #(
        .WIDTH (TICK_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_tick_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_tick),
        .o_full  (tq_full),
        .i_pop   (tq_pop),
        .o_data  (tq_tick),
        .o_empty (tq_empty)
    );

    i2cm_back #(
        .DELAY_WIDTH (DELAY_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_tick_valid (!tq_empty),
        .i_tick       (tq_tick),
        .o_tick_pop   (tq_pop),
        .i_res_full   (rq_full),
        .o_res_push   (rq_push),
        .o_res        (back_res)
    );

    i2cm_fifo #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rq_push),
        .i_data  (back_res),
        .o_full  (rq_full),
        .i_pop   (pop),
        .o_data  (rq_res),
        .o_empty (empty)
    );

    assign o_scl_level   = rq_res.scl_level;
    assign o_sda_level   = rq_res.sda_level;
    assign o_sda_drive   = rq_res.sda_drive;
    assign o_busy_res    = rq_res.busy_res;
    assign o_done_res    = rq_res.done_res;
    assign o_rx_byte     = rq_res.rx_byte;
    assign o_ack_missing = rq_res.ack_missing;

    // A finished command always leaves the sequencer idle.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_done_res |-> !o_busy_res)
        else $error("done result reported while still busy");

    // Both queues come out of reset empty, so no stale result is shown.
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> empty && !full)
        else $error("queues not empty right after reset");

    // The sequencer steps exactly when a tick is waiting and the result queue has room.
    a_step_pairing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tq_pop == rq_push) && (!tq_pop || (!tq_empty && !rq_full)))
        else $error("tick consumed without a matching result");

endmodule

>>> tb/i2c_master_bit_engine_checker.sv
// Checker for the I2C master bit engine: predicts each tick's pin state and compares results.
`timescale 1ns / 1ps

module i2c_master_bit_engine_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [i2cm_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [i2cm_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                            i_push,
    input  logic                            i_full,
    input  logic [2:0]                      i_func,
    input  logic [i2cm_pkg::BYTE_BITS-1:0]  i_tx_byte,
    input  logic                            i_ack_after_read,
    input  logic                            i_sda_sample,
    input  logic                            i_empty,
    input  logic                            i_pop,
    input  logic                            i_scl_level,
    input  logic                            i_sda_level,
    input  logic                            i_sda_drive,
    input  logic                            i_busy_res,
    input  logic                            i_done_res,
    input  logic [i2cm_pkg::BYTE_BITS-1:0]  i_rx_byte,
    input  logic                            i_ack_missing,
    output int                              o_fail_count,
    output int                              o_waiting
);
    import i2cm_pkg::*;

    localparam int REPORT_CAP = 100;

    // Configuration copy.
    logic [HALF_PERIOD_W-1:0] cfg_half;
    logic [POLL_LIMIT_W-1:0]  cfg_limit;

    // Sequencer state as the engine should hold it.
    t_phase               ph;
    logic [BYTE_BITS-1:0] shreg;
    logic [3:0]           nbits;
    logic [15:0]          dly;
    logic [7:0]           polls;
    logic                 scl_q;
    logic                 sda_q;
    logic                 drv_q;
    logic                 ack_bit;
    logic                 miss_flag;
    logic [BYTE_BITS-1:0] rx_last;
    logic                 done_now;

    t_result tick_results_due[$];
    int      fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic void clear_engine();
        cfg_half  = HALF_PERIOD_RST;
        cfg_limit = POLL_LIMIT_RST;
        ph        = PH_IDLE;
        shreg     = '0;
        nbits     = '0;
        dly       = '0;
        polls     = '0;
        scl_q     = 1'b1;
        sda_q     = 1'b1;
        drv_q     = 1'b1;
        ack_bit   = 1'b0;
        miss_flag = 1'b0;
        rx_last   = '0;
    endfunction

    function automatic void arm_delay(input t_phase next);
        dly = (cfg_half == '0) ? 16'd1 : cfg_half;
        ph  = next;
    endfunction

    function automatic void end_command();
        ph       = PH_IDLE;
        done_now = 1'b1;
    endfunction

    // Runs one pin-changing segment and any segments that follow it without a delay.
    function automatic void run_segments(input t_phase first, input logic sda_in);
        t_phase seg;
        logic   again;
        seg   = first;
        again = 1'b1;
        while (again) begin
            again = 1'b0;
            case (seg)
                PH_ST_A: begin
                    drv_q = 1'b1; scl_q = 1'b1; sda_q = 1'b1;
                    arm_delay(PH_ST_B);
                end
                PH_ST_B: begin sda_q = 1'b0; arm_delay(PH_ST_C); end
                PH_ST_C: begin scl_q = 1'b0; end_command(); end
                PH_SP_A: begin
                    drv_q = 1'b1; scl_q = 1'b0; sda_q = 1'b0;
                    arm_delay(PH_SP_B);
                end
                PH_SP_B: begin scl_q = 1'b1; arm_delay(PH_SP_C); end
                PH_SP_C: begin sda_q = 1'b1; arm_delay(PH_SP_D); end
                PH_SP_D: end_command();
                PH_WA_A: begin drv_q = 1'b0; sda_q = 1'b1; arm_delay(PH_WA_B); end
                PH_WA_B: begin scl_q = 1'b1; arm_delay(PH_WA_POLL); end
                PH_WA_POLL: begin
                    ph = PH_WA_POLL;
                    if (!sda_in) begin
                        scl_q     = 1'b0;
                        miss_flag = 1'b0;
                        end_command();
                    end else if (polls >= cfg_limit) begin
                        // Timed out: flag it and release the bus with a stop.
                        miss_flag = 1'b1;
                        seg       = PH_SP_A;
                        again     = 1'b1;
                    end else begin
                        polls = polls + 8'd1;
                    end
                end
                PH_TX_A: begin
                    drv_q = 1'b1;
                    sda_q = shreg[BYTE_BITS-1];
                    scl_q = 1'b1;
                    arm_delay(PH_TX_B);
                end
                PH_TX_B: begin scl_q = 1'b0; arm_delay(PH_TX_C); end
                PH_TX_C: begin
                    shreg = shreg << 1;
                    nbits = nbits + 4'd1;
                    if (nbits < BYTE_BITS) begin
                        seg   = PH_TX_A;
                        again = 1'b1;
                    end else begin
                        end_command();
                    end
                end
                PH_RX_A: begin drv_q = 1'b0; scl_q = 1'b0; arm_delay(PH_RX_B); end
                PH_RX_B: begin
                    scl_q = 1'b1;
                    shreg = {shreg[BYTE_BITS-2:0], sda_in};
                    nbits = nbits + 4'd1;
                    arm_delay(PH_RX_C);
                end
                PH_RX_C: begin
                    if (nbits < BYTE_BITS) begin
                        seg = PH_RX_A;
                    end else begin
                        rx_last = shreg;
                        seg     = PH_AK_A;
                    end
                    again = 1'b1;
                end
                PH_AK_A: begin
                    scl_q = 1'b0; drv_q = 1'b1; sda_q = ack_bit;
                    arm_delay(PH_AK_B);
                end
                PH_AK_B: begin scl_q = 1'b1; arm_delay(PH_AK_C); end
                PH_AK_C: begin scl_q = 1'b0; end_command(); end
                default: ph = PH_IDLE;
            endcase
        end
    endfunction

    function automatic t_result sequence_tick(input t_func f, input logic [BYTE_BITS-1:0] tx,
                                              input logic ar, input logic sda);
        t_result r;
        done_now = 1'b0;
        if (ph == PH_IDLE) begin
            if (f != FN_NONE) begin
                nbits = '0;
                polls = '0;
                case (f)
                    FN_START:    run_segments(PH_ST_A, sda);
                    FN_STOP:     run_segments(PH_SP_A, sda);
                    FN_SEND: begin
                        shreg = tx;
                        run_segments(PH_TX_A, sda);
                    end
                    FN_WAIT_ACK: run_segments(PH_WA_A, sda);
                    FN_RECV: begin
                        shreg   = '0;
                        ack_bit = !ar;
                        run_segments(PH_RX_A, sda);
                    end
                    FN_ACK: begin
                        ack_bit = 1'b0;
                        run_segments(PH_AK_A, sda);
                    end
                    default: begin
                        ack_bit = 1'b1;
                        run_segments(PH_AK_A, sda);
                    end
                endcase
            end
        end else if (ph == PH_WA_POLL) begin
            run_segments(PH_WA_POLL, sda);
        end else begin
            if (dly != '0) dly = dly - 16'd1;
            if (dly == '0) run_segments(ph, sda);
        end
        r.scl_level   = scl_q;
        r.sda_level   = sda_q;
        r.sda_drive   = drv_q;
        r.busy_res    = (ph != PH_IDLE);
        r.done_res    = done_now;
        r.rx_byte     = rx_last;
        r.ack_missing = miss_flag;
        return r;
    endfunction

    task automatic compare_field(input string fname, input int want, input int got);
        if (want != got) begin
            fail_count++;
            if (fail_count <= REPORT_CAP)
                $display("%0t: %s expected %0d, got %0d", $time, fname, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            clear_engine();
            tick_results_due.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (tick_results_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_CAP)
                        $display("%0t: result item with nothing expected, got scl %0d sda %0d",
                                 $time, i_scl_level, i_sda_level);
                end else begin
                    want = tick_results_due.pop_front();
                    compare_field("scl_level", want.scl_level, i_scl_level);
                    compare_field("sda_level", want.sda_level, i_sda_level);
                    compare_field("sda_drive", want.sda_drive, i_sda_drive);
                    compare_field("busy_res", want.busy_res, i_busy_res);
                    compare_field("done_res", want.done_res, i_done_res);
                    compare_field("rx_byte", want.rx_byte, i_rx_byte);
                    compare_field("ack_missing", want.ack_missing, i_ack_missing);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_HALF_PERIOD:    cfg_half  = i_cfg_wdata[HALF_PERIOD_W-1:0];
                    CFG_ACK_POLL_LIMIT: cfg_limit = i_cfg_wdata[POLL_LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (i_push && !i_full)
                tick_results_due.push_back(sequence_tick(t_func'(i_func), i_tx_byte,
                                                         i_ack_after_read, i_sda_sample));
        end
        o_waiting <= tick_results_due.size();
    end

endmodule

>>> tb/i2c_master_bit_engine_tb.sv
// Testbench top for the I2C master bit engine: clock, reset, tick stimulus and verdict.
`timescale 1ns / 1ps

module i2c_master_bit_engine_tb;
    import i2cm_pkg::*;

    localparam int LIMIT_CYCLES = 2_000_000;

    logic                  i_clk;
    logic                  i_rst_n          = 1'b0;
    logic                  i_cfg_we         = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr       = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata      = '0;
    logic                  push             = 1'b0;
    logic                  full;
    logic [2:0]            i_func           = '0;
    logic [BYTE_BITS-1:0]  i_tx_byte        = '0;
    logic                  i_ack_after_read = 1'b0;
    logic                  i_sda_sample     = 1'b0;
    logic                  empty;
    logic                  pop              = 1'b0;
    logic                  o_scl_level;
    logic                  o_sda_level;
    logic                  o_sda_drive;
    logic                  o_busy_res;
    logic                  o_done_res;
    logic [BYTE_BITS-1:0]  o_rx_byte;
    logic                  o_ack_missing;

    int fail_count;
    int waiting;
    int hp_cur     = 4;
    int lim_cur    = 250;
    int gap_pct    = 0;
    int stall_pct  = 0;
    int ticks_sent = 0;

    i2c_master_bit_engine dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .push            (push),
        .full            (full),
        .i_func          (i_func),
        .i_tx_byte       (i_tx_byte),
        .i_ack_after_read(i_ack_after_read),
        .i_sda_sample    (i_sda_sample),
        .empty           (empty),
        .pop             (pop),
        .o_scl_level     (o_scl_level),
        .o_sda_level     (o_sda_level),
        .o_sda_drive     (o_sda_drive),
        .o_busy_res      (o_busy_res),
        .o_done_res      (o_done_res),
        .o_rx_byte       (o_rx_byte),
        .o_ack_missing   (o_ack_missing)
    );

    i2c_master_bit_engine_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_push          (push),
        .i_full          (full),
        .i_func          (i_func),
        .i_tx_byte       (i_tx_byte),
        .i_ack_after_read(i_ack_after_read),
        .i_sda_sample    (i_sda_sample),
        .i_empty         (empty),
        .i_pop           (pop),
        .i_scl_level     (o_scl_level),
        .i_sda_level     (o_sda_level),
        .i_sda_drive     (o_sda_drive),
        .i_busy_res      (o_busy_res),
        .i_done_res      (o_done_res),
        .i_rx_byte       (o_rx_byte),
        .i_ack_missing   (o_ack_missing),
        .o_fail_count    (fail_count),
        .o_waiting       (waiting)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial begin
        int cyc;
        cyc = 0;
        while (cyc < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cyc++;
        end
        $display("Some tests failed");
        $finish;
    end

    function automatic int eff_half();
        return (hp_cur == 0) ? 1 : hp_cur;
    endfunction

    // Offers one item and returns at the edge where it is taken.
    task automatic tick(input t_func f, input logic [BYTE_BITS-1:0] tx, input logic ar,
                        input logic sda);
        while ($urandom_range(0, 99) < gap_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push             <= 1'b1;
        i_func           <= f;
        i_tx_byte        <= tx;
        i_ack_after_read <= ar;
        i_sda_sample     <= sda;
        do @(posedge i_clk); while (full);
        ticks_sent++;
    endtask

    task automatic quiet(input int n);
        int i;
        for (i = 0; i < n; i++)
            tick(FN_NONE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
    endtask

    // Issues one command and then enough further items for it to run out. For a wait for
    // ACK, lvl 0 acknowledges at once, 1 keeps SDA high until the timeout and 2 picks
    // either; for a receive it gives all zeros, all ones or random bits.
    task automatic command(input t_func f, input logic [BYTE_BITS-1:0] tx, input logic ar,
                           input int lvl, input int noise_pct);
        int   hpe;
        int   len;
        int   ack_at;
        int   i;
        logic miss;
        logic sda;
        t_func fn;
        hpe    = eff_half();
        miss   = (lvl == 1) || (lvl == 2 && $urandom_range(0, 4) == 0);
        ack_at = (lvl == 0) ? 0 : 2 * hpe + $urandom_range(0, 3);
        case (f)
            FN_START, FN_ACK, FN_NACK: len = 2 * hpe;
            FN_STOP:     len = 3 * hpe;
            FN_SEND:     len = 16 * hpe;
            FN_RECV:     len = 18 * hpe;
            FN_WAIT_ACK: len = miss ? 5 * hpe + lim_cur + 2 : 2 * hpe + 6;
            default:     len = 0;
        endcase
        len = len + $urandom_range(0, 2);
        tick(f, tx, ar, (lvl == 2) ? 1'($urandom_range(0, 1)) : lvl[0]);
        for (i = 0; i < len; i++) begin
            if (f == FN_WAIT_ACK)
                sda = miss ? 1'b1 : (i < ack_at);
            else
                sda = (lvl == 2) ? 1'($urandom_range(0, 1)) : lvl[0];
            fn = ($urandom_range(0, 99) < noise_pct) ? t_func'($urandom_range(1, 7)) : FN_NONE;
            tick(fn, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), sda);
        end
    endtask

    task automatic transaction();
        int n;
        int k;
        command(FN_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 2, 3);
        command(FN_SEND, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 2, 3);
        command(FN_WAIT_ACK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 2, 3);
        n = $urandom_range(1, 3);
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 1)) begin
                command(FN_SEND, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 2, 3);
                command(FN_WAIT_ACK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                        2, 3);
            end else begin
                command(FN_RECV, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 2, 3);
            end
        end
        command(FN_STOP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 2, 3);
    endtask

    // Mostly whole bus transfers, the rest loose commands and bare ticks.
    task automatic random_phase(input int n_items);
        int stop_at;
        int pick;
        stop_at = ticks_sent + n_items;
        while (ticks_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                transaction();
            else if (pick < 90)
                command(t_func'($urandom_range(1, 7)), 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)), 2, 10);
            else
                quiet($urandom_range(1, 6));
        end
    endtask

    task automatic settle();
        push <= 1'b0;
        @(posedge i_clk);
        while (waiting != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input int val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_HALF_PERIOD)
            hp_cur = val;
        else
            lim_cur = val;
    endtask

    task automatic reconfigure(input int hp, input int lim);
        settle();
        write_reg(CFG_HALF_PERIOD, hp);
        write_reg(CFG_ACK_POLL_LIMIT, lim);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part on the reset configuration.
        command(FN_NONE, 8'h00, 1'b0, 2, 0);
        command(FN_START, 8'h00, 1'b0, 2, 0);
        command(FN_SEND, 8'h00, 1'b0, 0, 0);
        command(FN_WAIT_ACK, 8'h00, 1'b0, 0, 0);
        command(FN_SEND, 8'hFF, 1'b1, 1, 0);
        command(FN_WAIT_ACK, 8'hFF, 1'b1, 1, 0);
        command(FN_START, 8'h00, 1'b0, 2, 0);
        command(FN_SEND, 8'hA5, 1'b0, 2, 0);
        command(FN_WAIT_ACK, 8'h5A, 1'b0, 2, 0);
        command(FN_RECV, 8'h00, 1'b1, 1, 0);
        command(FN_RECV, 8'hFF, 1'b0, 0, 0);
        command(FN_RECV, 8'h3C, 1'b1, 2, 0);
        command(FN_ACK, 8'h00, 1'b0, 2, 0);
        command(FN_NACK, 8'h00, 1'b1, 2, 0);
        command(FN_STOP, 8'h00, 1'b0, 2, 0);
        command(FN_STOP, 8'h00, 1'b0, 2, 0);
        // Commands offered while the engine is busy must be ignored.
        command(FN_SEND, 8'hC3, 1'b0, 2, 100);
        quiet(8);

        reconfigure(1, 1);
        gap_pct = 79;
        random_phase(120);

        reconfigure(2, 255);
        gap_pct   = 0;
        stall_pct = 79;
        random_phase(100);

        reconfigure(0, 0);
        gap_pct   = 38;
        stall_pct = 38;
        random_phase(80);

        reconfigure(1, 3);
        gap_pct   = 0;
        stall_pct = 0;
        random_phase(80);
        // Long enough for the longest command to finish so the engine ends idle.
        quiet(18 * eff_half() + lim_cur + 8);

        // A longer delay: a single start runs through both of its intervals.
        reconfigure(20, 2);
        command(FN_START, 8'h00, 1'b0, 2, 0);
        quiet(4);

        reconfigure(3, 2);
        gap_pct = 79;
        random_phase(80);

        settle();
        if (fail_count == 0 && waiting == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
